// ===== hw/rtl/hsfcp_pkg.sv =====
package hsfcp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned PosW     = 3;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [ByteW-1:0] HeaderFirstRst  = 8'hA5;
  localparam logic [ByteW-1:0] HeaderSecondRst = 8'h5A;
  localparam logic [ByteW-1:0] ResetOpcodeRst  = 8'h01;

  // position of the checksum byte; the frame is six bytes long
  localparam logic [PosW-1:0] PosChecksum = 3'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_RESET_OPCODE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_RESET_OK = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_UNKNOWN  = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] header_first;
    logic [ByteW-1:0] header_second;
    logic [ByteW-1:0] reset_opcode;
  } cfg_t;

  typedef struct packed {
    status_e           status;
    logic [ByteW-1:0]  command_code;
    logic [ValueW-1:0] command_value;
    logic              reset_request;
  } result_t;

endpackage

// ===== hw/rtl/hsfcp_cfg_regs.sv =====
module hsfcp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hsfcp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hsfcp_pkg::ByteW-1:0]    cfg_data_i,
  output hsfcp_pkg::cfg_t                cfg_o
);

  hsfcp_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (hsfcp_pkg::cfg_idx_e'(cfg_index_i))
        hsfcp_pkg::CFG_HEADER_FIRST:  cfg_d.header_first  = cfg_data_i;
        hsfcp_pkg::CFG_HEADER_SECOND: cfg_d.header_second = cfg_data_i;
        hsfcp_pkg::CFG_RESET_OPCODE:  cfg_d.reset_opcode  = cfg_data_i;
        default: ; // unmapped index: write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= hsfcp_pkg::HeaderFirstRst;
      cfg_q.header_second <= hsfcp_pkg::HeaderSecondRst;
      cfg_q.reset_opcode  <= hsfcp_pkg::ResetOpcodeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/hsfcp_parser.sv =====
module hsfcp_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hsfcp_pkg::cfg_t              cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [hsfcp_pkg::ByteW-1:0]  rx_byte_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output hsfcp_pkg::result_t           res_o
);

  logic                          byte_valid_q;
  logic [hsfcp_pkg::ByteW-1:0]   byte_q;
  logic [hsfcp_pkg::PosW-1:0]    pos_q, pos_d;
  logic [hsfcp_pkg::ByteW-1:0]   xor_q, xor_d;
  logic [hsfcp_pkg::ByteW-1:0]   cmd_q, cmd_d;
  logic [hsfcp_pkg::ValueW-1:0]  val_q, val_d;
  logic                          last_byte;
  logic                          consume;
  logic                          accept;

  // positions above the checksum slot cannot occur; treat them like it
  assign last_byte   = (pos_q >= hsfcp_pkg::PosChecksum);
  assign consume     = byte_valid_q && (!last_byte || res_ready_i);
  assign in_stall_o  = byte_valid_q && !consume;
  assign accept      = in_valid_i && !in_stall_o;
  assign res_valid_o = byte_valid_q && last_byte;

  always_comb begin
    pos_d = pos_q;
    xor_d = xor_q;
    cmd_d = cmd_q;
    val_d = val_q;
    case (pos_q)
      3'd0: begin
        if (byte_q == cfg_i.header_first) begin
          xor_d = byte_q;
          pos_d = 3'd1;
        end
      end
      3'd1: begin
        // second header is checked first so equal headers still sync
        if (byte_q == cfg_i.header_second) begin
          xor_d = xor_q ^ byte_q;
          pos_d = 3'd2;
        end else if (byte_q == cfg_i.header_first) begin
          xor_d = byte_q;
        end else begin
          pos_d = 3'd0;
        end
      end
      3'd2: begin
        cmd_d = byte_q;
        xor_d = xor_q ^ byte_q;
        pos_d = 3'd3;
      end
      3'd3: begin
        val_d = {byte_q, {hsfcp_pkg::ByteW{1'b0}}};
        xor_d = xor_q ^ byte_q;
        pos_d = 3'd4;
      end
      3'd4: begin
        val_d = {val_q[hsfcp_pkg::ValueW-1:hsfcp_pkg::ByteW], byte_q};
        xor_d = xor_q ^ byte_q;
        pos_d = 3'd5;
      end
      default: begin
        pos_d = 3'd0;
        xor_d = '0;
      end
    endcase
  end

  always_comb begin
    res_o.command_code  = cmd_q;
    res_o.command_value = val_q;
    res_o.reset_request = 1'b0;
    if (xor_q != byte_q) begin
      res_o.status = hsfcp_pkg::ST_CHECKSUM;
    end else if (cmd_q != cfg_i.reset_opcode || val_q != '0) begin
      res_o.status = hsfcp_pkg::ST_UNKNOWN;
    end else begin
      res_o.status        = hsfcp_pkg::ST_RESET_OK;
      res_o.reset_request = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_valid_q <= 1'b0;
      pos_q        <= '0;
      xor_q        <= '0;
      cmd_q        <= '0;
      val_q        <= '0;
    end else begin
      if (accept) begin
        byte_valid_q <= 1'b1;
      end else if (consume) begin
        byte_valid_q <= 1'b0;
      end
      if (consume) begin
        pos_q <= pos_d;
        xor_q <= xor_d;
        cmd_q <= cmd_d;
        val_q <= val_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= rx_byte_i;
    end
  end

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= hsfcp_pkg::PosChecksum)
    else $error("frame position out of range");

  a_stall_only_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (res_valid_o && !res_ready_i))
    else $error("input stalled without a blocked result");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && last_byte) |=> (pos_q == '0 && xor_q == '0))
    else $error("parser did not restart after checksum byte");

  a_req_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.reset_request == (res_o.status == hsfcp_pkg::ST_RESET_OK)))
    else $error("reset request disagrees with frame status");

endmodule

// ===== hw/rtl/hsfcp_out_reg.sv =====
module hsfcp_out_reg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           res_valid_i,
  output logic                           res_ready_o,
  input  hsfcp_pkg::result_t             res_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     frame_status_o,
  output logic [hsfcp_pkg::ByteW-1:0]    command_code_o,
  output logic [hsfcp_pkg::ValueW-1:0]   command_value_o,
  output logic                           reset_request_o
);

  logic               valid_q;
  hsfcp_pkg::result_t res_q;
  logic               load;

  assign res_ready_o = !valid_q || !out_stall_i;
  assign load        = res_valid_i && res_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o     = valid_q;
  assign frame_status_o  = res_q.status;
  assign command_code_o  = res_q.command_code;
  assign command_value_o = res_q.command_value;
  assign reset_request_o = res_q.reset_request;

endmodule

// ===== hw/rtl/header_sync_frame_command_parser_top.sv =====
// Six-byte frame parser: header_first, header_second, command, value high,
// value low, XOR checksum of the five bytes before it.
// Byte input: in_valid_i / in_stall_o / rx_byte_i; a transfer happens when
// valid is high and stall is low. One byte per cycle is taken unless stalled.
// Result output: out_valid_o / out_stall_i with frame_status_o, command_code_o,
// command_value_o and reset_request_o; one result per completed frame, none
// for the other bytes.
// A checksum byte's result reaches the outputs through the input register and
// then the result register.
// A stalled result holds in the result register; the input side keeps taking
// bytes until a second finished frame would need the result register, then
// in_stall_o rises until the receiver takes the pending result.
// Config: cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i; ready is
// always high. Index 0 header_first, 1 header_second, 2 reset_opcode; other
// indexes are ignored. Write only while no frame byte is in flight.
// Reset: registers return to 0xA5 / 0x5A / 0x01, the parser waits for a
// header and no result is pending.
module header_sync_frame_command_parser_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hsfcp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hsfcp_pkg::ByteW-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [hsfcp_pkg::ByteW-1:0]    rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     frame_status_o,
  output logic [hsfcp_pkg::ByteW-1:0]    command_code_o,
  output logic [hsfcp_pkg::ValueW-1:0]   command_value_o,
  output logic                           reset_request_o
);

  hsfcp_pkg::cfg_t    cfg;
  hsfcp_pkg::result_t res;
  logic               res_valid;
  logic               res_ready;

  hsfcp_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hsfcp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  hsfcp_out_reg u_out_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_ready_o     (res_ready),
    .res_i           (res),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .frame_status_o  (frame_status_o),
    .command_code_o  (command_code_o),
    .command_value_o (command_value_o),
    .reset_request_o (reset_request_o)
  );

endmodule

// ===== verif/frame_result_checker.sv =====
module frame_result_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [hsfcp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hsfcp_pkg::ByteW-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [hsfcp_pkg::ByteW-1:0]    rx_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [1:0]                     frame_status_i,
  input  logic [hsfcp_pkg::ByteW-1:0]    command_code_i,
  input  logic [hsfcp_pkg::ValueW-1:0]   command_value_i,
  input  logic                           reset_request_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    frames_checked_o,
  output int unsigned                    resets_seen_o,
  output int unsigned                    pending_o,
  output logic                           frame_open_o
);

  hsfcp_pkg::cfg_t              regs;
  logic [hsfcp_pkg::PosW-1:0]   rx_pos;
  logic [hsfcp_pkg::ByteW-1:0]  rx_xor;
  logic [hsfcp_pkg::ByteW-1:0]  rx_cmd;
  logic [hsfcp_pkg::ValueW-1:0] rx_value;
  hsfcp_pkg::result_t           expected_frames[$];

  int unsigned n_fail = 0;
  int unsigned n_frames = 0;
  int unsigned n_resets = 0;

  assign fail_count_o     = n_fail;
  assign frames_checked_o = n_frames;
  assign resets_seen_o    = n_resets;

  // advance the frame parser by one byte; returns 1 when the frame completes
  function automatic logic parse_rx_byte(input logic [hsfcp_pkg::ByteW-1:0] b,
                                         output hsfcp_pkg::result_t r);
    r = '0;
    case (rx_pos)
      3'd0: begin
        if (b == regs.header_first) begin
          rx_xor = b;
          rx_pos = 3'd1;
        end
      end
      3'd1: begin
        // second header wins when both registers hold the same value
        if (b == regs.header_second) begin
          rx_xor ^= b;
          rx_pos = 3'd2;
        end else if (b == regs.header_first) begin
          rx_xor = b;
        end else begin
          rx_pos = 3'd0;
        end
      end
      3'd2: begin
        rx_cmd = b;
        rx_xor ^= b;
        rx_pos = 3'd3;
      end
      3'd3: begin
        rx_value = {b, 8'h00};
        rx_xor ^= b;
        rx_pos = 3'd4;
      end
      3'd4: begin
        rx_value[7:0] = b;
        rx_xor ^= b;
        rx_pos = hsfcp_pkg::PosChecksum;
      end
      default: begin
        if (rx_xor != b) begin
          r.status = hsfcp_pkg::ST_CHECKSUM;
        end else if (rx_cmd != regs.reset_opcode || rx_value != '0) begin
          r.status = hsfcp_pkg::ST_UNKNOWN;
        end else begin
          r.status = hsfcp_pkg::ST_RESET_OK;
          r.reset_request = 1'b1;
        end
        r.command_code  = rx_cmd;
        r.command_value = rx_value;
        rx_pos = 3'd0;
        rx_xor = '0;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hsfcp_pkg::result_t want;
    hsfcp_pkg::result_t pred;
    if (!rst_ni) begin
      regs.header_first  = hsfcp_pkg::HeaderFirstRst;
      regs.header_second = hsfcp_pkg::HeaderSecondRst;
      regs.reset_opcode  = hsfcp_pkg::ResetOpcodeRst;
      rx_pos   = '0;
      rx_xor   = '0;
      rx_cmd   = '0;
      rx_value = '0;
      expected_frames.delete();
      pending_o    <= 0;
      frame_open_o <= 1'b0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_frames.size() == 0) begin
          $error("result with no frame pending: command_code %0h", command_code_i);
          n_fail++;
        end else begin
          want = expected_frames.pop_front();
          n_frames++;
          if (reset_request_i) n_resets++;
          if (frame_status_i != want.status) begin
            $error("frame_status expected %0d got %0d", want.status, frame_status_i);
            n_fail++;
          end
          if (command_code_i != want.command_code) begin
            $error("command_code expected %0h got %0h", want.command_code, command_code_i);
            n_fail++;
          end
          if (command_value_i != want.command_value) begin
            $error("command_value expected %0h got %0h", want.command_value,
                   command_value_i);
            n_fail++;
          end
          if (reset_request_i != want.reset_request) begin
            $error("reset_request expected %0b got %0b", want.reset_request,
                   reset_request_i);
            n_fail++;
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (hsfcp_pkg::cfg_idx_e'(cfg_index_i))
          hsfcp_pkg::CFG_HEADER_FIRST:  regs.header_first  = cfg_data_i;
          hsfcp_pkg::CFG_HEADER_SECOND: regs.header_second = cfg_data_i;
          hsfcp_pkg::CFG_RESET_OPCODE:  regs.reset_opcode  = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (parse_rx_byte(rx_byte_i, pred)) expected_frames.push_back(pred);
      end

      pending_o    <= expected_frames.size();
      frame_open_o <= (rx_pos != '0);
    end
  end

endmodule

// ===== verif/tb_header_sync_frame_command_parser_top.sv =====
module tb_header_sync_frame_command_parser_top;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 4;
  localparam logic [hsfcp_pkg::CfgIdxW-1:0] CfgIdxSpare = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [hsfcp_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [hsfcp_pkg::ByteW-1:0]    cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [hsfcp_pkg::ByteW-1:0]    rx_byte = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b1;
  logic [1:0]                     frame_status;
  logic [hsfcp_pkg::ByteW-1:0]    command_code;
  logic [hsfcp_pkg::ValueW-1:0]   command_value;
  logic                           reset_request;

  int unsigned fail_count;
  int unsigned frames_checked;
  int unsigned resets_seen;
  int unsigned pending;
  logic        frame_open;

  // stimulus-side copy of the registers, used only to shape frames
  logic [hsfcp_pkg::ByteW-1:0] hf_cur = hsfcp_pkg::HeaderFirstRst;
  logic [hsfcp_pkg::ByteW-1:0] hs_cur = hsfcp_pkg::HeaderSecondRst;
  logic [hsfcp_pkg::ByteW-1:0] op_cur = hsfcp_pkg::ResetOpcodeRst;
  logic                        burst_mode = 1'b0;
  int unsigned                 bytes_sent = 0;
  int unsigned                 idle_cycles = 0;

  header_sync_frame_command_parser_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .frame_status_o  (frame_status),
    .command_code_o  (command_code),
    .command_value_o (command_value),
    .reset_request_o (reset_request)
  );

  frame_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .rx_byte_i        (rx_byte),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .frame_status_i   (frame_status),
    .command_code_i   (command_code),
    .command_value_i  (command_value),
    .reset_request_i  (reset_request),
    .fail_count_o     (fail_count),
    .frames_checked_o (frames_checked),
    .resets_seen_o    (resets_seen),
    .pending_o        (pending),
    .frame_open_o     (frame_open)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // result receiver: random stall before each transfer, none in burst mode
  initial begin
    int unsigned hold;
    forever begin
      hold = burst_mode ? 0 : $urandom_range(18, 0);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // watchdog: ends the run when no transfer happens for too long
  initial begin
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_byte(input logic [hsfcp_pkg::ByteW-1:0] b);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(18, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk_i); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [hsfcp_pkg::ByteW-1:0] cmd,
                            input logic [hsfcp_pkg::ByteW-1:0] vh,
                            input logic [hsfcp_pkg::ByteW-1:0] vl, input logic corrupt,
                            input logic repeat_hdr);
    logic [hsfcp_pkg::ByteW-1:0] chk;
    chk = hf_cur ^ hs_cur ^ cmd ^ vh ^ vl;
    if (corrupt) chk ^= 8'($urandom_range(255, 1));
    if (repeat_hdr) send_byte(hf_cur);
    send_byte(hf_cur);
    send_byte(hs_cur);
    send_byte(cmd);
    send_byte(vh);
    send_byte(vl);
    send_byte(chk);
  endtask

  task automatic send_random_frame();
    logic [hsfcp_pkg::ByteW-1:0] cmd;
    logic [hsfcp_pkg::ByteW-1:0] vh;
    logic [hsfcp_pkg::ByteW-1:0] vl;
    cmd = ($urandom_range(1, 0) != 0) ? op_cur : 8'($urandom);
    {vh, vl} = ($urandom_range(1, 0) != 0) ? 16'h0000 : 16'($urandom);
    send_frame(cmd, vh, vl, $urandom_range(4, 0) == 0, $urandom_range(7, 0) == 0);
  endtask

  // header then a truncated body; the next bytes may get parsed as frame data
  task automatic send_broken_frame();
    int unsigned n;
    n = $urandom_range(4, 0);
    send_byte(hf_cur);
    repeat (n) send_byte(8'($urandom));
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned pick;
    while (bytes_sent < target) begin
      if ($urandom_range(7, 0) == 0) burst_mode = ~burst_mode;
      pick = $urandom_range(9, 0);
      if (pick < 7) send_random_frame();
      else if (pick == 7) send_broken_frame();
      else send_byte(8'($urandom));
      if ($urandom_range(24, 0) == 0) wait_results_drained();
    end
  endtask

  // finish any open frame with filler, drain the results, then write registers
  task automatic reconfigure(input logic [hsfcp_pkg::ByteW-1:0] hf,
                             input logic [hsfcp_pkg::ByteW-1:0] hs,
                             input logic [hsfcp_pkg::ByteW-1:0] op);
    logic [hsfcp_pkg::ByteW-1:0] filler;
    filler = 8'h00;
    while (filler == hf_cur || filler == hs_cur) filler++;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (frame_open) begin
      send_byte(filler);
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= hsfcp_pkg::CFG_HEADER_FIRST;
    cfg_data  <= hf;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= hsfcp_pkg::CFG_HEADER_SECOND;
    cfg_data  <= hs;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_index <= hsfcp_pkg::CFG_RESET_OPCODE;
    cfg_data  <= op;
    do @(posedge clk_i); while (!cfg_ready);
    // unmapped index: must leave every register alone
    cfg_index <= CfgIdxSpare;
    cfg_data  <= 8'($urandom);
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hf_cur = hf;
    hs_cur = hs;
    op_cur = op;
  endtask

  initial begin
    logic [hsfcp_pkg::ByteW-1:0] same_hdr;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle noise, reset accepted, unknown with header repeat,
    // bad second header, checksum mismatch
    send_byte(8'h00);
    send_frame(op_cur, 8'h00, 8'h00, 1'b0, 1'b0);
    send_frame(8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1);
    send_byte(hf_cur);
    send_byte(8'h33);
    send_frame(op_cur, 8'h00, 8'h00, 1'b1, 1'b0);
    wait_results_drained();

    run_random(190);
    reconfigure(8'h00, 8'hFF, 8'hFF);
    run_random(360);
    reconfigure(8'hFF, 8'h00, 8'h00);
    run_random(530);
    same_hdr = 8'($urandom);
    reconfigure(same_hdr, same_hdr, 8'($urandom));
    run_random(700);
    reconfigure(8'($urandom), 8'($urandom), 8'($urandom));
    run_random(870);

    wait_results_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d bytes over five register settings (extremes, equal headers)",
             bytes_sent);
    $display("checked %0d frame results, %0d of them reset requests",
             frames_checked, resets_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== header_sync_frame_command_parser_top.f =====
hw/rtl/hsfcp_pkg.sv
hw/rtl/hsfcp_cfg_regs.sv
hw/rtl/hsfcp_parser.sv
hw/rtl/hsfcp_out_reg.sv
hw/rtl/header_sync_frame_command_parser_top.sv
verif/frame_result_checker.sv
verif/tb_header_sync_frame_command_parser_top.sv
